[src/swc_pkg.sv]
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants of the square-wave channel
// Register indexes, item kinds, divider handshake types and lookup tables.
// ----------------------------------------------------------------------------
package swc_pkg;

	// Serial divider widths: the largest dividend is the 17-bit base frequency,
	// the largest divisor is a 14-bit channel frequency.
	localparam int DIV_W = 17;
	localparam int DSR_W = 14;

	localparam int INPUT_CLOCK = 1790000;
	localparam int CLOCK_DIV   = 16;
	localparam int SAMPLE_RATE = 44100;

	localparam logic [DIV_W-1:0] FREQ_BASE = DIV_W'(INPUT_CLOCK / CLOCK_DIV);
	localparam logic [DIV_W-1:0] OUT_RATE  = DIV_W'(SAMPLE_RATE);

	localparam logic [11:0] PERIOD_MIN = 12'd8;
	localparam logic [11:0] PERIOD_MAX = 12'h7FF;
	localparam logic [3:0]  LEVEL_MAX  = 4'hF;

	// Item kinds.
	localparam logic [2:0] KIND_RENDER     = 3'd0;
	localparam logic [2:0] KIND_ENV_TICK   = 3'd1;
	localparam logic [2:0] KIND_SWEEP_TICK = 3'd2;
	localparam logic [2:0] KIND_LEN_TICK   = 3'd3;
	localparam logic [2:0] KIND_LOAD       = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_DUTY_MODE     = 3'd0;
	localparam logic [2:0] REG_HALT_LOOP     = 3'd1;
	localparam logic [2:0] REG_CONST_VOLUME  = 3'd2;
	localparam logic [2:0] REG_VOLUME_DECAY  = 3'd3;
	localparam logic [2:0] REG_SWEEP_ON      = 3'd4;
	localparam logic [2:0] REG_SWEEP_DIVIDER = 3'd5;
	localparam logic [2:0] REG_SWEEP_DOWN    = 3'd6;
	localparam logic [2:0] REG_SWEEP_AMOUNT  = 3'd7;

	localparam logic [7:0] LEN_TABLE [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	localparam logic [7:0] DUTY_BITS [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};

	typedef struct packed {
		logic [1:0] duty_mode;
		logic       halt_loop;
		logic       constant_volume;
		logic [3:0] volume_or_decay;
		logic       sweep_on;
		logic [2:0] sweep_divider;
		logic       sweep_down;
		logic [2:0] sweep_amount;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_POS,
		ST_DIV_FREQ,
		ST_DIV_SPC,
		ST_RESULT
	} state_t;

endpackage

[src/square_wave_channel_top.sv]
// ----------------------------------------------------------------------------
// square_wave_channel_top: square-wave sound channel
// Configuration registers, item sequencer, serial divider and output register.
// ----------------------------------------------------------------------------
// Envelope, sweep-without-update, length and unused items finish without leaving
// the idle state; a muted render, or one made before the samples per waveform
// cycle are known, goes straight to the result state and frees the input once
// the output register takes its result; an audible render first runs one 17-step
// division. A load or a sweep update that leaves the channel audible runs two
// 17-step divisions back to back through the one serial divider.
// One item is in work at a time; the result register frees the input side.
// Reset (arst_n low) clears the channel state, the settings and the valid
// flags at once; the divider and output data registers wait for their first load.
module square_wave_channel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [10:0] new_period,
	input  logic [4:0]  length_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  sample,
	output logic        muted,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import swc_pkg::*;

	cfg_t     cfg_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic       res_valid;
	logic       res_ready;
	logic [3:0] res_sample;
	logic       res_muted;
	logic       out_valid_q;
	logic [3:0] sample_q;
	logic       muted_q;

	// Configuration writes land at once; the user must change the registers only
	// while the channel is idle, unenforced here, so the sequencer sees them steady.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DUTY_MODE:     cfg_q.duty_mode       <= cfg_data[1:0];
				REG_HALT_LOOP:     cfg_q.halt_loop       <= cfg_data[0];
				REG_CONST_VOLUME:  cfg_q.constant_volume <= cfg_data[0];
				REG_VOLUME_DECAY:  cfg_q.volume_or_decay <= cfg_data;
				REG_SWEEP_ON:      cfg_q.sweep_on        <= cfg_data[0];
				REG_SWEEP_DIVIDER: cfg_q.sweep_divider   <= cfg_data[2:0];
				REG_SWEEP_DOWN:    cfg_q.sweep_down      <= cfg_data[0];
				REG_SWEEP_AMOUNT:  cfg_q.sweep_amount    <= cfg_data[2:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// The sequencer owns all channel state and decides when the divider runs.
	swc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.new_period   (new_period),
		.length_index (length_index),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_sample   (res_sample),
		.res_muted    (res_muted),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	// One shared divider serves the duty position, the channel frequency and
	// the samples per waveform cycle, one quotient bit per clock.
	swc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output register: a finished result waits here for its transfer while the
	// sequencer goes back to taking items.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			sample_q <= res_sample;
			muted_q  <= res_muted;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign muted     = muted_q;

endmodule

[src/swc_div.sv]
// ----------------------------------------------------------------------------
// swc_div: bit-serial restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module swc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  swc_pkg::div_req_t req,
	output swc_pkg::div_rsp_t rsp
);
	import swc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The dividend register shifts out its bits and fills with quotient bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

[src/swc_ctrl.sv]
// ----------------------------------------------------------------------------
// swc_ctrl: channel state and item sequencer
// Holds the channel state, runs each item and drives the serial divider.
// ----------------------------------------------------------------------------
module swc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  swc_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [10:0]       new_period,
	input  logic [4:0]        length_index,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [3:0]        res_sample,
	output logic              res_muted,
	output swc_pkg::div_req_t div_req,
	input  swc_pkg::div_rsp_t div_rsp
);
	import swc_pkg::*;

	function automatic logic silence_of(input logic [11:0] period, input logic down);
		return (period < PERIOD_MIN) || (!down && (period > PERIOD_MAX));
	endfunction

	state_t state_q;
	state_t state_d;

	logic [11:0] timer_period_q;
	logic [7:0]  length_left_q;
	logic [3:0]  env_level_q;
	logic [3:0]  env_div_q;
	logic        env_restart_q;
	logic [2:0]  sweep_count_q;
	logic        sweep_reload_q;
	logic        silenced_q;
	logic [9:0]  spc_q;
	logic [9:0]  sample_pos_q;
	logic [3:0]  res_sample_q;
	logic        res_muted_q;

	logic        accept;
	logic        muted_now;
	logic        sweep_fire;
	logic [11:0] delta;
	logic [11:0] swept_period;
	logic        swept_silenced;
	logic        load_silenced;
	logic [11:0] period_next;
	logic [2:0]  pos;
	logic [3:0]  volume;
	logic [3:0]  sample_val;
	logic [9:0]  pos_inc;
	logic [9:0]  pos_next;
	logic [DSR_W-1:0] freq;

	assign accept         = in_valid && in_ready;
	assign muted_now      = (length_left_q == '0) || silenced_q;
	assign sweep_fire     = cfg.sweep_on && !silenced_q && (sweep_count_q == '0);
	assign delta          = timer_period_q >> cfg.sweep_amount;
	assign swept_period   = cfg.sweep_down ? timer_period_q - delta : timer_period_q + delta;
	assign swept_silenced = silence_of(swept_period, cfg.sweep_down);
	assign load_silenced  = silence_of({1'b0, new_period}, cfg.sweep_down);
	assign period_next    = (kind == KIND_LOAD) ? {1'b0, new_period} : swept_period;

	// Duty position: the divided position clamped to 7, or 0 without a division.
	assign pos = (state_q != ST_DIV_POS) ? 3'd0 :
		(|div_rsp.quotient[DIV_W-1:3]) ? 3'd7 : div_rsp.quotient[2:0];
	assign volume     = cfg.constant_volume ? cfg.volume_or_decay : env_level_q;
	assign sample_val = DUTY_BITS[cfg.duty_mode][3'd7 - pos] ? volume : 4'd0;
	assign pos_inc    = sample_pos_q + 1'b1;
	assign pos_next   = (pos_inc >= spc_q) ? 10'd0 : pos_inc;

	// A zero channel frequency is forced to one.
	assign freq = (div_rsp.quotient[DSR_W-1:0] == '0) ? DSR_W'(1) :
		div_rsp.quotient[DSR_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_RENDER: begin
							state_d = (muted_now || spc_q == '0) ? ST_RESULT : ST_DIV_POS;
						end
						KIND_SWEEP_TICK: begin
							if (sweep_fire && !swept_silenced) begin
								state_d = ST_DIV_FREQ;
							end
						end
						KIND_LOAD: begin
							if (!load_silenced) begin
								state_d = ST_DIV_FREQ;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV_POS: begin
				if (div_rsp.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_DIV_FREQ: begin
				if (div_rsp.done) begin
					state_d = ST_DIV_SPC;
				end
			end
			ST_DIV_SPC: begin
				if (div_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		res_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = FREQ_BASE;
		div_req.divisor  = DSR_W'(period_next) + 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (kind == KIND_RENDER) begin
					div_req.dividend = DIV_W'({sample_pos_q, 3'b000});
					div_req.divisor  = DSR_W'(spc_q);
				end
				div_req.start = (state_d == ST_DIV_POS) || (state_d == ST_DIV_FREQ);
			end
			ST_DIV_FREQ: begin
				div_req.dividend = OUT_RATE;
				div_req.divisor  = freq;
				div_req.start    = div_rsp.done;
			end
			ST_RESULT: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			timer_period_q <= '0;
			length_left_q  <= '0;
			env_level_q    <= '0;
			env_div_q      <= '0;
			env_restart_q  <= 1'b0;
			sweep_count_q  <= '0;
			sweep_reload_q <= 1'b0;
			silenced_q     <= 1'b0;
			spc_q          <= '0;
			sample_pos_q   <= '0;
			res_sample_q   <= '0;
			res_muted_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept) begin
				case (kind)
					KIND_RENDER: begin
						if (muted_now) begin
							res_sample_q <= 4'd0;
							res_muted_q  <= 1'b1;
						end else if (spc_q == '0) begin
							res_sample_q <= sample_val;
							res_muted_q  <= 1'b0;
							sample_pos_q <= '0;
						end
					end
					KIND_ENV_TICK: begin
						if (env_restart_q) begin
							env_div_q     <= cfg.volume_or_decay;
							env_level_q   <= LEVEL_MAX;
							env_restart_q <= 1'b0;
						end else if (env_div_q != '0) begin
							env_div_q <= env_div_q - 1'b1;
						end else begin
							env_div_q <= cfg.volume_or_decay;
							if (env_level_q != '0) begin
								env_level_q <= env_level_q - 1'b1;
							end else if (cfg.halt_loop) begin
								env_level_q <= LEVEL_MAX;
							end
						end
					end
					KIND_SWEEP_TICK: begin
						if (sweep_reload_q) begin
							sweep_reload_q <= 1'b0;
							sweep_count_q  <= cfg.sweep_divider;
						end else if (sweep_fire) begin
							sweep_count_q <= cfg.sweep_divider;
						end else if (cfg.sweep_on && !silenced_q) begin
							sweep_count_q <= sweep_count_q - 1'b1;
						end
						if (sweep_fire) begin
							timer_period_q <= swept_period;
							silenced_q     <= swept_silenced;
						end
					end
					KIND_LEN_TICK: begin
						if (!cfg.halt_loop && length_left_q != '0) begin
							length_left_q <= length_left_q - 1'b1;
						end
					end
					KIND_LOAD: begin
						timer_period_q <= {1'b0, new_period};
						length_left_q  <= LEN_TABLE[length_index];
						env_restart_q  <= 1'b1;
						sweep_reload_q <= 1'b1;
						silenced_q     <= load_silenced;
					end
					default: begin
						silenced_q <= silenced_q;
					end
				endcase
			end
			if (state_q == ST_DIV_POS && div_rsp.done) begin
				res_sample_q <= sample_val;
				res_muted_q  <= 1'b0;
				sample_pos_q <= pos_next;
			end
			if (state_q == ST_DIV_SPC && div_rsp.done) begin
				spc_q <= div_rsp.quotient[9:0];
			end
		end
	end

	assign res_sample = res_sample_q;
	assign res_muted  = res_muted_q;

endmodule

[src/swc_checker.sv]
// ----------------------------------------------------------------------------
// swc_checker: port-level checks of the square-wave channel
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module swc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] sample,
	input logic       muted
);
	import swc_pkg::*;

	// No result is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// A result waits until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transfer");

	// A muted result always carries a zero sample.
	a_muted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && muted |-> sample == 4'd0)
		else $error("muted result with nonzero sample");

	// A render keeps the channel busy for at least the next cycle.
	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_RENDER |=> !in_ready)
		else $error("item taken right after a render");

	// An item other than a render never creates a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind != KIND_RENDER && !out_valid |=> !out_valid)
		else $error("result appeared without a render");

endmodule

bind square_wave_channel_top swc_checker u_swc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample    (sample),
	.muted     (muted)
);

[verif/square_wave_channel_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for square_wave_channel_top
// Drives renders, envelope, sweep and length ticks, loads and unused kinds over
// valid/ready, keeps a cycle-free copy of the channel state to predict every
// rendered sample, and compares each sample transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import swc_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	// Longest no-result item: a load with two serial divisions.
	localparam int QUIET_CYCLES = 60;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 75;

	// Kinds the block ignores.
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [3:0] sample;
		logic       muted;
	} chan_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  kind;
	logic [10:0] new_period;
	logic [4:0]  length_index;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  sample;
	logic        muted;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [3:0]  cfg_data;

	square_wave_channel_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.new_period   (new_period),
		.length_index (length_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample),
		.muted        (muted),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Shadow copy of the channel: settings and state as the block should hold them.
	cfg_t        chan_cfg;
	logic [11:0] period_q;
	logic [7:0]  length_q;
	logic [3:0]  env_level;
	logic [3:0]  env_div;
	logic        env_restart;
	logic [2:0]  sweep_cnt;
	logic        sweep_reload;
	logic        silenced;
	logic [9:0]  spc;
	logic [9:0]  spos;

	chan_result_t expected_samples[$];

	int idle_pct;
	int stall_pct;
	int mismatch_count;
	int cycle_count;
	int n_transfers;
	int n_loads;
	int n_renders;
	int n_checked;
	int n_cfg_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost sample ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples still expected", cycle_count,
				expected_samples.size());
			$display("square_wave_channel_top test failed");
			$finish;
		end
	end

	// Recompute the silence flag and, when audible, the samples per waveform cycle.
	function automatic void refresh_pitch();
		int freq;
		silenced = (period_q < PERIOD_MIN) || (!chan_cfg.sweep_down && period_q > PERIOD_MAX);
		if (!silenced) begin
			freq = int'(FREQ_BASE) / (int'(period_q) + 1);
			if (freq == 0)
				freq = 1;
			spc = 10'(int'(OUT_RATE) / freq);
		end
	endfunction

	// Apply one accepted item to the shadow state and queue the sample it yields.
	function automatic void advance_channel(logic [2:0] k, logic [10:0] p, logic [4:0] li);
		int           pos;
		logic [11:0]  delta;
		chan_result_t res;
		case (k)
			KIND_RENDER: begin
				res.muted  = (length_q == 0) || silenced;
				res.sample = 4'd0;
				if (!res.muted) begin
					pos = 0;
					if (spc != 0) begin
						pos = (int'(spos) * 8) / int'(spc);
						if (pos > 7)
							pos = 7;
					end
					spos = spos + 10'd1;
					if (spos >= spc)
						spos = 10'd0;
					if (DUTY_BITS[chan_cfg.duty_mode][7 - pos])
						res.sample = chan_cfg.constant_volume ? chan_cfg.volume_or_decay : env_level;
				end
				expected_samples.push_back(res);
			end
			KIND_ENV_TICK: begin
				if (env_restart) begin
					env_div     = chan_cfg.volume_or_decay;
					env_level   = LEVEL_MAX;
					env_restart = 1'b0;
				end else if (env_div > 0) begin
					env_div--;
				end else begin
					env_div = chan_cfg.volume_or_decay;
					if (env_level > 0)
						env_level--;
					else if (chan_cfg.halt_loop)
						env_level = LEVEL_MAX;
				end
			end
			KIND_SWEEP_TICK: begin
				if (chan_cfg.sweep_on && !silenced) begin
					if (sweep_cnt > 0) begin
						sweep_cnt--;
					end else begin
						delta     = period_q >> chan_cfg.sweep_amount;
						sweep_cnt = chan_cfg.sweep_divider;
						period_q  = chan_cfg.sweep_down ? period_q - delta : period_q + delta;
						refresh_pitch();
					end
				end
				if (sweep_reload) begin
					sweep_reload = 1'b0;
					sweep_cnt    = chan_cfg.sweep_divider;
				end
			end
			KIND_LEN_TICK: begin
				if (!chan_cfg.halt_loop && length_q > 0)
					length_q--;
			end
			KIND_LOAD: begin
				period_q     = {1'b0, p};
				length_q     = LEN_TABLE[li];
				env_restart  = 1'b1;
				sweep_reload = 1'b1;
				refresh_pitch();
			end
			default: ;
		endcase
	endfunction

	// One input transfer: random idle cycles first, then hold valid until accepted.
	task automatic send_item(logic [2:0] k, logic [10:0] p, logic [4:0] li);
		@(negedge clk);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		new_period   <= p;
		length_index <= li;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		advance_channel(k, p, li);
		n_transfers++;
		if (k == KIND_LOAD)
			n_loads++;
		if (k == KIND_RENDER)
			n_renders++;
	endtask

	// Stop sending, let every expected sample arrive and the block settle.
	task automatic await_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// cfg_we stays high across a burst; set_config lowers it after the last write.
	task automatic write_reg(logic [2:0] idx, logic [3:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		n_cfg_writes++;
	endtask

	task automatic set_config(cfg_t c);
		await_quiet();
		write_reg(REG_DUTY_MODE, 4'(c.duty_mode));
		write_reg(REG_HALT_LOOP, 4'(c.halt_loop));
		write_reg(REG_CONST_VOLUME, 4'(c.constant_volume));
		write_reg(REG_VOLUME_DECAY, c.volume_or_decay);
		write_reg(REG_SWEEP_ON, 4'(c.sweep_on));
		write_reg(REG_SWEEP_DIVIDER, 4'(c.sweep_divider));
		write_reg(REG_SWEEP_DOWN, 4'(c.sweep_down));
		write_reg(REG_SWEEP_AMOUNT, 4'(c.sweep_amount));
		@(negedge clk);
		cfg_we   <= 1'b0;
		chan_cfg = c;
	endtask

	// Receiver: stall at random, and check every sample transfer in order.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		chan_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample transfer: sample=%0d muted=%0d", $time,
					sample, muted);
				mismatch_count++;
			end else begin
				want = expected_samples.pop_front();
				n_checked++;
				if (sample !== want.sample) begin
					$display("%0t: sample mismatch: expected %0d, actual %0d", $time,
						want.sample, sample);
					mismatch_count++;
				end
				if (muted !== want.muted) begin
					$display("%0t: muted mismatch: expected %0d, actual %0d", $time,
						want.muted, muted);
					mismatch_count++;
				end
			end
		end
	end

	// Reset state: a render before any load is muted; unused kinds change nothing.
	task automatic test_reset_defaults();
		send_item(KIND_RENDER, 11'd0, 5'd0);
		send_item(KIND_SPARE_FIRST, 11'h7FF, 5'd31);
		send_item(KIND_SPARE_MID, 11'h555, 5'd21);
		send_item(KIND_SPARE_LAST, 11'h2AA, 5'd10);
		send_item(KIND_LOAD, 11'd0, 5'd0);
		send_item(KIND_RENDER, 11'h7FF, 5'd31);
	endtask

	// Every setting at its maximum: constant full volume, 75% duty, and a sweep
	// down by period >> 7 whenever the slowest sweep divider runs out.
	task automatic test_extreme_settings();
		set_config('1);
		send_item(KIND_LOAD, 11'h7FF, 5'd31);
		send_item(KIND_RENDER, 11'd0, 5'd0);
		send_item(KIND_RENDER, 11'd0, 5'd0);
		send_item(KIND_SWEEP_TICK, 11'd0, 5'd0);
		send_item(KIND_RENDER, 11'd0, 5'd0);
		// Shortest audible period: three samples per waveform cycle.
		send_item(KIND_LOAD, PERIOD_MIN[10:0], 5'd1);
		repeat (3) send_item(KIND_RENDER, 11'd0, 5'd0);
		send_item(KIND_LEN_TICK, 11'd0, 5'd0);
		send_item(KIND_ENV_TICK, 11'd0, 5'd0);
	endtask

	// Sweep down by the whole period silences the channel; the length runs out.
	task automatic test_sweep_and_length();
		cfg_t c;
		c = '0;
		c.sweep_on   = 1'b1;
		c.sweep_down = 1'b1;
		set_config(c);
		send_item(KIND_LOAD, 11'd7, 5'd3);
		send_item(KIND_LOAD, 11'd9, 5'd3);
		send_item(KIND_ENV_TICK, 11'd0, 5'd0);
		send_item(KIND_RENDER, 11'd0, 5'd0);
		send_item(KIND_SWEEP_TICK, 11'd0, 5'd0);
		send_item(KIND_SWEEP_TICK, 11'd0, 5'd0);
		send_item(KIND_RENDER, 11'd0, 5'd0);
		send_item(KIND_LEN_TICK, 11'd0, 5'd0);
		send_item(KIND_LEN_TICK, 11'd0, 5'd0);
		send_item(KIND_RENDER, 11'd0, 5'd0);
	endtask

	// Random traffic: each phase starts with a load and then mostly renders and
	// ticks, with a load now and then, so waveforms, envelopes and sweeps play out.
	task automatic test_random_traffic();
		int   idle_plan[4]  = '{0, 85, 0, 16};
		int   stall_plan[4] = '{0, 0, 85, 16};
		int   sent;
		int   pick;
		int   r;
		cfg_t c;
		logic [10:0] per;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				c = '0;
			else if (ph == 1)
				c = '1;
			else
				c = cfg_t'(16'($urandom));
			set_config(c);
			idle_pct  = idle_plan[ph % 4];
			stall_pct = stall_plan[ph % 4];
			sent = 0;
			pick = 0;
			while (sent < PHASE_ITEMS) begin
				if (sent != 0)
					pick = $urandom_range(99);
				if (pick < 7) begin
					// Mostly short periods so that whole duty cycles are rendered.
					r = $urandom_range(99);
					if (r < 70)
						per = 11'($urandom_range(120, PERIOD_MIN));
					else if (r < 88)
						per = 11'($urandom);
					else if (r < 94)
						per = 11'($urandom_range(PERIOD_MIN - 1, 0));
					else
						per = PERIOD_MAX[10:0] - 11'($urandom_range(3));
					send_item(KIND_LOAD, per, 5'($urandom));
				end else if (pick < 62) begin
					send_item(KIND_RENDER, 11'($urandom), 5'($urandom));
				end else if (pick < 74) begin
					send_item(KIND_ENV_TICK, 11'($urandom), 5'($urandom));
				end else if (pick < 84) begin
					send_item(KIND_SWEEP_TICK, 11'($urandom), 5'($urandom));
				end else if (pick < 94) begin
					send_item(KIND_LEN_TICK, 11'($urandom), 5'($urandom));
				end else if (pick < 97) begin
					send_item(3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)),
						11'($urandom), 5'($urandom));
					continue;
				end else begin
					// Hold the sender back until the receiver has caught up.
					await_quiet();
					send_item(KIND_RENDER, 11'($urandom), 5'($urandom));
				end
				sent++;
			end
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_RENDER;
		new_period   = 11'd0;
		length_index = 5'd0;
		cfg_we       = 1'b0;
		cfg_index    = REG_DUTY_MODE;
		cfg_data     = 4'd0;
		idle_pct     = 0;
		stall_pct    = 0;
		chan_cfg     = '0;
		period_q     = '0;
		length_q     = '0;
		env_level    = '0;
		env_div      = '0;
		env_restart  = 1'b0;
		sweep_cnt    = '0;
		sweep_reload = 1'b0;
		silenced     = 1'b0;
		spc          = '0;
		spos         = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_extreme_settings();
		test_sweep_and_length();
		test_random_traffic();
		await_quiet();

		$display("Run covered %0d input transfers (%0d loads, %0d renders) and %0d checked samples,",
			n_transfers, n_loads, n_renders, n_checked);
		$display("with %0d register writes over %0d settings and four idle/stall mixes.",
			n_cfg_writes, PHASES + 2);
		if (mismatch_count == 0 && expected_samples.size() == 0) begin
			$display("square_wave_channel_top test passed");
		end else begin
			$display("%0d mismatches, %0d samples never arrived", mismatch_count,
				expected_samples.size());
			$display("square_wave_channel_top test failed");
		end
		$finish;
	end

endmodule
